### design/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rcf assertion failed");
`define RCF_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rcf forbidden condition");
`else
`define RCF_ASSERT(lbl, clk, rst, prop)
`define RCF_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### design/rcf_pkg.sv
`default_nettype none
package rcf_pkg;
  localparam int MAX_INPUT  = 8;
  localparam int MAX_HIDDEN = 16;
  localparam int MAX_OUTPUT = 8;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int ACC_W      = 40;
  localparam int IN_AW      = $clog2(MAX_INPUT);
  localparam int HID_AW     = $clog2(MAX_HIDDEN);
  localparam int OUT_AW     = $clog2(MAX_OUTPUT);
  localparam int U_AW       = IN_AW + HID_AW;
  localparam int W_AW       = HID_AW + HID_AW;
  localparam int V_AW       = HID_AW + OUT_AW;

  localparam logic [1:0] CFG_INPUT_LEN  = 2'd0;
  localparam logic [1:0] CFG_HIDDEN_LEN = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_LEN = 2'd2;

  localparam logic       REQ_LOAD   = 1'b0;
  localparam logic       REQ_SAMPLE = 1'b1;
  localparam logic [1:0] SEL_U      = 2'd0;
  localparam logic [1:0] SEL_W      = 2'd1;
  localparam logic [1:0] SEL_V      = 2'd2;

  typedef enum logic [1:0] {OP_ACC, OP_REC, OP_OUT} op_kind_t;

  typedef struct packed {
    logic                   req_type;
    logic [1:0]             matrix_select;
    logic [3:0]             row;
    logic [3:0]             col;
    logic signed [15:0]     value;
    logic                   seq_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [2:0]         out_index;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    logic                         valid;
    op_kind_t                     kind;
    logic                         first;
    logic                         last;
    logic [HID_AW-1:0]            tag;
    logic signed [DATA_WIDTH-1:0] opnd;
  } mac_op_t;

  typedef struct packed {
    logic                         valid;
    op_kind_t                     kind;
    logic [HID_AW-1:0]            tag;
    logic signed [DATA_WIDTH-1:0] value;
  } mac_res_t;

  function automatic logic [11:0] tanh_pt(input logic [4:0] idx);
    logic [11:0] p;
    unique case (idx)
      5'd0: p = 12'd0;     5'd1: p = 12'd1003;  5'd2: p = 12'd1893;
      5'd3: p = 12'd2602;  5'd4: p = 12'd3119;  5'd5: p = 12'd3475;
      5'd6: p = 12'd3707;  5'd7: p = 12'd3856;  5'd8: p = 12'd3949;
      5'd9: p = 12'd4006;  5'd10: p = 12'd4041; 5'd11: p = 12'd4062;
      5'd12: p = 12'd4076; 5'd13: p = 12'd4084; 5'd14: p = 12'd4089;
      5'd15: p = 12'd4091; 5'd16: p = 12'd4093;
      default: p = 12'd4093;
    endcase
    return p;
  endfunction

  // odd piecewise-linear tanh, saturating at magnitude four
  function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
    logic [16:0] a;
    logic [11:0] p0;
    logic [10:0] d;
    logic [20:0] m;
    logic [12:0] y;
    a  = x[15] ? 17'(-$signed({x[15], x})) : 17'({1'b0, x});
    p0 = tanh_pt({1'b0, a[13:10]});
    d  = 11'(tanh_pt({1'b0, a[13:10]} + 5'd1) - p0);
    m  = 21'(d) * 21'(a[9:0]) + 21'd512;
    y  = (a >= 17'd16384) ? 13'd4093 : 13'(p0) + 13'(m[20:10]);
    return x[15] ? -$signed(16'(y)) : $signed(16'(y));
  endfunction
endpackage
`default_nettype wire

### design/rnn_cell_forward_unit.sv
// channel  | dir | payload     | handshake
// in       | in  | in_item_t   | in_valid / in_stall
// out      | out | out_item_t  | out_valid / out_stall
// cfg      | in  | 5-bit data  | cfg_en, cfg_index
// a load is written straight to its ram; a sample issues one mac a cycle, one per hidden unit
// a closing sample then issues the recurrent products and one product chain per output
// the single shared multiply-accumulate unit and one read port per weight ram set the pace
// rst is synchronous: lengths return to max, hidden state and accumulators clear
// out_stall only holds the output register; the next output waits until it is taken
`default_nettype none
`include "assert_macros.svh"
module rnn_cell_forward_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rcf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rcf_pkg::out_item_t      out_data,
  input  wire logic               cfg_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [4:0]         cfg_data
);
  import rcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_ADRAIN, S_REC, S_RDRAIN, S_OUT, S_ODRAIN
  } state_t;

  state_t                state;
  logic [3:0]            input_len;
  logic [4:0]            hidden_len;
  logic [3:0]            output_len;
  logic [3:0]            cnt;
  logic [3:0]            elem;
  logic                  fresh;
  logic                  closing;
  logic signed [15:0]    x;
  logic [HID_AW-1:0]     n;
  logic [HID_AW-1:0]     r;
  logic [OUT_AW-1:0]     k;
  logic signed [15:0]    h     [MAX_HIDDEN];
  logic signed [15:0]    hnext [MAX_HIDDEN];

  // clamped lengths
  logic [3:0]            il;
  logic [HID_AW-1:0]     hlm;
  logic [OUT_AW-1:0]     olm;
  logic [3:0]            cnt_next;
  logic                  accept;
  logic                  last_n;
  logic                  last_r;

  mac_op_t               op;
  mac_res_t              res;
  logic                  busy;
  logic                  acc_clear;
  logic [U_AW-1:0]       u_raddr;
  logic [W_AW-1:0]       w_raddr;
  logic [V_AW-1:0]       v_raddr;
  logic [15:0]           u_rdata;
  logic [15:0]           w_rdata;
  logic [15:0]           v_rdata;
  logic                  u_we;
  logic                  w_we;
  logic                  v_we;

  always_comb begin
    il  = (input_len == '0) ? 4'd1 :
          (input_len > 4'(MAX_INPUT)) ? 4'(MAX_INPUT) : input_len;
    hlm = (hidden_len == '0) ? '0 :
          (hidden_len > 5'(MAX_HIDDEN)) ? HID_AW'(MAX_HIDDEN - 1) :
          HID_AW'(hidden_len - 5'd1);
    olm = (output_len == '0) ? '0 :
          (output_len > 4'(MAX_OUTPUT)) ? OUT_AW'(MAX_OUTPUT - 1) :
          OUT_AW'(output_len - 4'd1);
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cnt_next = cnt + 4'd1;
  assign last_n   = (n == hlm);
  assign last_r   = (r == hlm);

  // weight loads go straight to the rams; out-of-range targets are dropped
  assign u_we = accept && in_data.req_type == REQ_LOAD && in_data.matrix_select == SEL_U
                && in_data.row < 4'(MAX_INPUT);
  assign w_we = accept && in_data.req_type == REQ_LOAD && in_data.matrix_select == SEL_W;
  assign v_we = accept && in_data.req_type == REQ_LOAD && in_data.matrix_select == SEL_V
                && in_data.col < 4'(MAX_OUTPUT);

  // mac issue: one product per cycle, but output products wait while the output register is full
  always_comb begin
    op       = '0;
    op.kind  = OP_ACC;
    u_raddr  = {elem[IN_AW-1:0], n};
    w_raddr  = {r, n};
    v_raddr  = {r, k};
    unique case (state)
      S_ACC: begin
        op.valid = 1'b1;
        op.kind  = OP_ACC;
        op.tag   = n;
        op.opnd  = x;
      end
      S_REC: begin
        op.valid = 1'b1;
        op.kind  = OP_REC;
        op.tag   = n;
        op.first = (r == '0);
        op.last  = last_r;
        op.opnd  = fresh ? '0 : h[r];
      end
      S_OUT: begin
        op.valid = !out_valid;
        op.kind  = OP_OUT;
        op.tag   = HID_AW'(k);
        op.first = (r == '0);
        op.last  = last_r;
        op.opnd  = h[r];
      end
      default: ;
    endcase
  end

  assign acc_clear = (state == S_RDRAIN) && !busy;

  rcf_wram #(.DEPTH(MAX_INPUT * MAX_HIDDEN), .AW(U_AW), .DW(DATA_WIDTH)) u_uram (
    .clk(clk), .we(u_we), .waddr({in_data.row[IN_AW-1:0], in_data.col[HID_AW-1:0]}),
    .wdata(in_data.value), .raddr(u_raddr), .rdata(u_rdata)
  );
  rcf_wram #(.DEPTH(MAX_HIDDEN * MAX_HIDDEN), .AW(W_AW), .DW(DATA_WIDTH)) u_wram (
    .clk(clk), .we(w_we), .waddr({in_data.row[HID_AW-1:0], in_data.col[HID_AW-1:0]}),
    .wdata(in_data.value), .raddr(w_raddr), .rdata(w_rdata)
  );
  rcf_wram #(.DEPTH(MAX_HIDDEN * MAX_OUTPUT), .AW(V_AW), .DW(DATA_WIDTH)) u_vram (
    .clk(clk), .we(v_we), .waddr({in_data.row[HID_AW-1:0], in_data.col[OUT_AW-1:0]}),
    .wdata(in_data.value), .raddr(v_raddr), .rdata(v_rdata)
  );

  rcf_mac u_mac (
    .clk(clk), .rst(rst), .op(op),
    .u_rdata(u_rdata), .w_rdata(w_rdata), .v_rdata(v_rdata),
    .acc_clear(acc_clear), .busy(busy), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      input_len  <= 4'd8;
      hidden_len <= 5'd16;
      output_len <= 4'd8;
      cnt        <= '0;
      fresh      <= 1'b1;
      closing    <= 1'b0;
      out_valid  <= 1'b0;
      n          <= '0;
      r          <= '0;
      k          <= '0;
      for (int i = 0; i < MAX_HIDDEN; i++) h[i] <= '0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          CFG_INPUT_LEN:  input_len  <= cfg_data[3:0];
          CFG_HIDDEN_LEN: hidden_len <= cfg_data;
          CFG_OUTPUT_LEN: output_len <= cfg_data[3:0];
          default: ;
        endcase
      end
      // output register: drain on transfer, fill from the mac result
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (res.valid && res.kind == OP_OUT) begin
        out_valid          <= 1'b1;
        out_data.out_value <= res.value;
        out_data.out_index <= 3'(res.tag);
        out_data.out_last  <= (OUT_AW'(res.tag) == olm);
      end
      if (res.valid && res.kind == OP_REC) begin
        hnext[res.tag] <= res.value;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && in_data.req_type == REQ_SAMPLE) begin
            elem <= cnt;
            x    <= in_data.value;
            n    <= '0;
            if (cnt == '0 && in_data.seq_start) fresh <= 1'b1;
            if (cnt_next >= il || cnt_next == '0) begin
              closing <= 1'b1;
              cnt     <= '0;
            end else begin
              closing <= 1'b0;
              cnt     <= cnt_next;
            end
            state <= (cnt < 4'(MAX_INPUT)) ? S_ACC : S_ADRAIN;
          end
        end
        S_ACC: begin
          n <= n + 1'b1;
          if (last_n) state <= S_ADRAIN;
        end
        S_ADRAIN: begin
          if (!busy) begin
            n     <= '0;
            r     <= '0;
            state <= closing ? S_REC : S_IDLE;
          end
        end
        S_REC: begin
          if (last_r) begin
            r <= '0;
            n <= n + 1'b1;
            if (last_n) state <= S_RDRAIN;
          end else begin
            r <= r + 1'b1;
          end
        end
        S_RDRAIN: begin
          // commit the new hidden state; unused units read as zero
          if (!busy) begin
            for (int i = 0; i < MAX_HIDDEN; i++) begin
              h[i] <= (HID_AW'(i) <= hlm) ? hnext[i] : '0;
            end
            fresh <= 1'b0;
            k     <= '0;
            r     <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            if (last_r) begin
              r     <= '0;
              state <= S_ODRAIN;
            end else begin
              r <= r + 1'b1;
            end
          end
        end
        S_ODRAIN: begin
          if (!busy) begin
            if (k == olm) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_OUT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an item is only taken with the mac pipeline empty
  `RCF_ASSERT(a_accept_idle, clk, rst, accept |-> !busy)
  // an output product is only started while the output register is free
  `RCF_ASSERT_NEVER(a_out_overrun, clk, rst, op.valid && op.kind == OP_OUT && out_valid)
  // the last flag is only set on the final output index
  `RCF_ASSERT(a_last_index, clk, rst,
    (out_valid && out_data.out_last) |-> (out_data.out_index == 3'(olm)))
endmodule
`default_nettype wire

### design/rcf_wram.sv
`default_nettype none
module rcf_wram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/rcf_mac.sv
`default_nettype none
module rcf_mac (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire rcf_pkg::mac_op_t                        op,
  input  wire logic signed [rcf_pkg::DATA_WIDTH-1:0]   u_rdata,
  input  wire logic signed [rcf_pkg::DATA_WIDTH-1:0]   w_rdata,
  input  wire logic signed [rcf_pkg::DATA_WIDTH-1:0]   v_rdata,
  input  wire logic                                    acc_clear,
  output logic                                         busy,
  output rcf_pkg::mac_res_t                            res
);
  import rcf_pkg::*;

  mac_op_t                    s1;
  mac_op_t                    s2;
  logic signed [31:0]         prod;
  logic signed [ACC_W-1:0]    accum [MAX_HIDDEN];
  logic signed [ACC_W-1:0]    sum;
  logic signed [ACC_W-1:0]    fin;
  logic signed [ACC_W-1:0]    base;
  logic signed [ACC_W-1:0]    cur;
  logic                       fin_v;
  op_kind_t                   fin_kind;
  logic [HID_AW-1:0]          fin_tag;
  logic                       q_v;
  op_kind_t                   q_kind;
  logic [HID_AW-1:0]          q_tag;
  logic signed [15:0]         q;
  logic signed [15:0]         rd;
  logic signed [ACC_W:0]      rnd;
  logic signed [ACC_W-FRAC_BITS:0] shf;
  logic signed [15:0]         qn;

  always_comb begin
    unique case (s1.kind)
      OP_ACC:  rd = u_rdata;
      OP_REC:  rd = w_rdata;
      default: rd = v_rdata;
    endcase
    base = (s2.kind == OP_REC) ? accum[s2.tag] : '0;
    cur  = (s2.first ? base : sum) + ACC_W'(prod);
    // round half up, floor, saturate
    rnd  = (ACC_W+1)'(fin) + (ACC_W+1)'(1 <<< (FRAC_BITS - 1));
    shf  = rnd[ACC_W:FRAC_BITS];
    if (shf > (ACC_W-FRAC_BITS+1)'(32767)) begin
      qn = 16'sd32767;
    end else if (shf < -(ACC_W-FRAC_BITS+1)'(32768)) begin
      qn = -16'sd32768;
    end else begin
      qn = shf[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      fin_v     <= 1'b0;
      q_v       <= 1'b0;
      res.valid <= 1'b0;
      for (int i = 0; i < MAX_HIDDEN; i++) accum[i] <= '0;
    end else begin
      s1     <= op;
      s2     <= s1;
      prod   <= s1.opnd * rd;
      fin_v  <= 1'b0;
      if (s2.valid) begin
        if (s2.kind == OP_ACC) begin
          accum[s2.tag] <= accum[s2.tag] + ACC_W'(prod);
        end else begin
          sum <= cur;
          if (s2.last) begin
            fin      <= cur;
            fin_v    <= 1'b1;
            fin_kind <= s2.kind;
            fin_tag  <= s2.tag;
          end
        end
      end
      q_v    <= fin_v;
      q_kind <= fin_kind;
      q_tag  <= fin_tag;
      q      <= qn;
      res.valid <= q_v;
      res.kind  <= q_kind;
      res.tag   <= q_tag;
      res.value <= (q_kind == OP_REC) ? tanh_q(q) : q;
      if (acc_clear) begin
        for (int i = 0; i < MAX_HIDDEN; i++) accum[i] <= '0;
      end
    end
  end

  assign busy = s1.valid | s2.valid | fin_v | q_v | res.valid;
endmodule
`default_nettype wire

### verif/rnn_cell_forward_checker.sv
`timescale 1ns / 1ps
module rnn_cell_forward_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rcf_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rcf_pkg::out_item_t out_data,
  input  logic               cfg_en,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  output int                 pending,
  output int                 errors
);
  import rcf_pkg::*;

  logic [3:0] in_len_reg;
  logic [4:0] hid_len_reg;
  logic [3:0] out_len_reg;
  logic signed [15:0] u_wt [MAX_INPUT][MAX_HIDDEN];
  logic signed [15:0] w_wt [MAX_HIDDEN][MAX_HIDDEN];
  logic signed [15:0] v_wt [MAX_HIDDEN][MAX_OUTPUT];
  logic signed [15:0] hid_state [MAX_HIDDEN];
  longint hid_acc [MAX_HIDDEN];
  logic [3:0] elem_cnt;
  logic fresh;
  out_item_t expected_outputs [$];

  function automatic int knot(input int k);
    case (k)
      0: return 0;     1: return 1003;  2: return 1893;  3: return 2602;
      4: return 3119;  5: return 3475;  6: return 3707;  7: return 3856;
      8: return 3949;  9: return 4006;  10: return 4041; 11: return 4062;
      12: return 4076; 13: return 4084; 14: return 4089; 15: return 4091;
      default: return 4093;
    endcase
  endfunction

  function automatic int clamp_len(input int v, input int top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // round half up to q4.12 then saturate
  function automatic logic signed [15:0] round_sat(input longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic logic signed [15:0] tanh_approx(input logic signed [15:0] x);
    int a;
    int y;
    int seg;
    int d;
    a = (x < 0) ? -int'(x) : int'(x);
    if (a >= 16384) begin
      y = 4093;
    end else begin
      seg = a >> 10;
      d = knot(seg + 1) - knot(seg);
      y = knot(seg) + ((d * (a & 1023) + 512) >>> 10);
    end
    return 16'((x < 0) ? -y : y);
  endfunction

  task automatic predict_transfer(input in_item_t it);
    int il, hl, ol;
    logic signed [15:0] nxt [MAX_HIDDEN];
    longint acc;
    out_item_t o;
    il = clamp_len(in_len_reg, MAX_INPUT);
    hl = clamp_len(hid_len_reg, MAX_HIDDEN);
    ol = clamp_len(out_len_reg, MAX_OUTPUT);
    if (it.req_type == REQ_LOAD) begin
      if (it.matrix_select == SEL_U && it.row < MAX_INPUT)
        u_wt[it.row][it.col] = it.value;
      else if (it.matrix_select == SEL_W)
        w_wt[it.row][it.col] = it.value;
      else if (it.matrix_select == SEL_V && it.col < MAX_OUTPUT)
        v_wt[it.row][it.col] = it.value;
      return;
    end
    if (elem_cnt == 0 && it.seq_start) fresh = 1'b1;
    if (elem_cnt < MAX_INPUT)
      for (int n = 0; n < hl; n++)
        hid_acc[n] += longint'(it.value) * longint'(u_wt[elem_cnt][n]);
    elem_cnt = elem_cnt + 4'd1;
    if (elem_cnt != 0 && elem_cnt < il) return;
    for (int n = 0; n < MAX_HIDDEN; n++) begin
      nxt[n] = '0;
      if (n < hl) begin
        acc = hid_acc[n];
        if (!fresh)
          for (int r = 0; r < hl; r++)
            acc += longint'(hid_state[r]) * longint'(w_wt[r][n]);
        nxt[n] = tanh_approx(round_sat(acc));
      end
    end
    for (int n = 0; n < MAX_HIDDEN; n++) begin
      hid_state[n] = nxt[n];
      hid_acc[n] = 0;
    end
    elem_cnt = '0;
    fresh = 1'b0;
    for (int k = 0; k < ol; k++) begin
      acc = 0;
      for (int r = 0; r < hl; r++)
        acc += longint'(hid_state[r]) * longint'(v_wt[r][k]);
      o.out_value = round_sat(acc);
      o.out_index = 3'(k);
      o.out_last = (k + 1 == ol);
      expected_outputs.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      in_len_reg = 4'd8;
      hid_len_reg = 5'd16;
      out_len_reg = 4'd8;
      foreach (hid_state[n]) begin
        hid_state[n] = '0;
        hid_acc[n] = 0;
      end
      foreach (u_wt[i, j]) u_wt[i][j] = '0;
      foreach (w_wt[i, j]) w_wt[i][j] = '0;
      foreach (v_wt[i, j]) v_wt[i][j] = '0;
      elem_cnt = '0;
      fresh = 1'b1;
      expected_outputs.delete();
      errors = 0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_INPUT_LEN:  in_len_reg = cfg_data[3:0];
          CFG_HIDDEN_LEN: hid_len_reg = cfg_data;
          CFG_OUTPUT_LEN: out_len_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_transfer(in_data);
      if (out_valid && !out_stall) begin
        if (expected_outputs.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output transfer %p", out_data);
        end else begin
          e = expected_outputs.pop_front();
          if (e.out_value !== out_data.out_value || e.out_index !== out_data.out_index
              || e.out_last !== out_data.out_last) begin
            errors++;
            if (errors <= 10)
              $display("output mismatch: expected val %0d idx %0d last %0d, got %0d %0d %0d",
                       e.out_value, e.out_index, e.out_last,
                       out_data.out_value, out_data.out_index, out_data.out_last);
          end
        end
      end
    end
    pending = expected_outputs.size();
  end
endmodule

### verif/rnn_cell_forward_unit_test.sv
`timescale 1ns / 1ps
module rnn_cell_forward_unit_test;
  import rcf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_en = 1'b0;
  logic [1:0] cfg_index = CFG_INPUT_LEN;
  logic [4:0] cfg_data = '0;
  int pending;
  int errors;
  // no idling on either side while set
  logic calm = 1'b0;

  rnn_cell_forward_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rnn_cell_forward_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always #2 clk = ~clk;

  // watchdog for a hung block
  initial begin
    #3_000_000;
    $display("rnn_cell_forward_unit regression: fail");
    $finish;
  end

  // receiver stalls about a third of the time
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  // mostly modest magnitudes so sums stay in range, sometimes full scale
  function automatic logic [15:0] rand_val();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8191) - 4096);
  endfunction

  // one input transfer, sometimes with a random gap before it
  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load(input logic [1:0] sel, input int r, input int c,
                      input logic [15:0] v);
    in_item_t it;
    it.req_type = REQ_LOAD;
    it.matrix_select = sel;
    it.row = 4'(r);
    it.col = 4'(c);
    it.value = v;
    it.seq_start = 1'($urandom);
    send_item(it);
  endtask

  task automatic sample(input logic [15:0] v, input logic start);
    in_item_t it;
    it.req_type = REQ_SAMPLE;
    it.matrix_select = 2'($urandom);
    it.row = 4'($urandom);
    it.col = 4'($urandom);
    it.value = v;
    it.seq_start = start;
    send_item(it);
  endtask

  // hold off until every expected output is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int v);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 5'(v);
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic set_lengths(input int il, input int hl, input int ol);
    write_reg(CFG_INPUT_LEN, il);
    write_reg(CFG_HIDDEN_LEN, hl);
    write_reg(CFG_OUTPUT_LEN, ol);
  endtask

  task automatic random_item();
    int pick;
    int sel;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      sample(rand_val(), $urandom_range(0, 4) == 0);
    end else if (pick < 95) begin
      sel = $urandom_range(0, 2);
      if (sel == SEL_U) load(SEL_U, $urandom_range(0, 7), $urandom_range(0, 15), rand_val());
      else if (sel == SEL_W) load(SEL_W, $urandom_range(0, 15), $urandom_range(0, 15), rand_val());
      else load(SEL_V, $urandom_range(0, 15), $urandom_range(0, 7), rand_val());
    end else begin
      // out-of-bounds or nonexistent target, must be dropped
      case ($urandom_range(0, 2))
        0: load(2'd3, $urandom_range(0, 15), $urandom_range(0, 15), rand_val());
        1: load(SEL_U, $urandom_range(8, 15), $urandom_range(0, 15), rand_val());
        default: load(SEL_V, $urandom_range(0, 15), $urandom_range(8, 15), rand_val());
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every weight so no unwritten entry is ever read
    calm = 1'b1;
    for (int r = 0; r < MAX_INPUT; r++)
      for (int c = 0; c < MAX_HIDDEN; c++) load(SEL_U, r, c, rand_val());
    for (int r = 0; r < MAX_HIDDEN; r++)
      for (int c = 0; c < MAX_HIDDEN; c++) load(SEL_W, r, c, rand_val());
    for (int r = 0; r < MAX_HIDDEN; r++)
      for (int c = 0; c < MAX_OUTPUT; c++) load(SEL_V, r, c, rand_val());
    calm = 1'b0;

    // directed: full-scale samples on the reset lengths, first step after reset
    sample(16'h7fff, 1'b0);
    sample(16'h8000, 1'b0);
    for (int i = 0; i < 6; i++) sample(16'($urandom), 1'b1);  // late seq_start ignored
    sample(16'h0000, 1'b1);                                   // fresh sequence
    sample(16'hffff, 1'b0);
    load(2'd3, 15, 15, 16'h7fff);
    load(SEL_U, 8, 3, 16'h8000);
    load(SEL_V, 2, 8, 16'h1234);
    drain();

    // shrink input_len with a step half done
    set_lengths(1, 16, 8);
    sample(16'h1000, 1'b0);
    drain();
    write_reg(CFG_INPUT_LEN, 8);
    for (int i = 0; i < 3; i++) sample(rand_val(), 1'b0);
    drain();
    write_reg(CFG_INPUT_LEN, 2);
    sample(16'h0800, 1'b0);
    drain();

    // random phases across length settings, zero and over-range included
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_lengths(0, 0, 0);
        1: set_lengths(15, 31, 15);
        2: set_lengths(8, 16, 8);
        3: set_lengths(1, 1, 1);
        default: set_lengths($urandom_range(1, 8), $urandom_range(1, 16),
                             $urandom_range(1, 8));
      endcase
      calm = (ph == 2);
      for (int i = 0; i < 18; i++) random_item();
      calm = 1'b0;
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("rnn_cell_forward_unit regression: pass");
    end else begin
      $display("rnn_cell_forward_unit regression: fail");
    end
    $finish;
  end
endmodule
